>>> hdl/foccl_pkg.sv
package foccl_pkg;

    localparam int ADC_BITS = 12;

    localparam int GAIN_W  = 24;
    localparam int POWER_W = 16;
    localparam int HALL_W  = 3;
    localparam int OUT_W   = 32;
    localparam int TRIG_W  = 16;

    // Internal widths that follow from the converter resolution.
    localparam int SUM_W  = ADC_BITS + 2;
    localparam int IA_W   = ADC_BITS + 14;
    localparam int IB_W   = ADC_BITS + 16;
    localparam int ERR_W  = ADC_BITS + 8;

    // Shared multiplier and accumulator.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 60;

    // Scaled quadrature voltage, split into two multiplier-sized pieces.
    localparam int VQS_W  = 43;
    localparam int LO_W   = 21;
    localparam int HI_W   = VQS_W - LO_W;

    localparam int SH_W = 6;
    localparam logic [SH_W-1:0] SH_PARK  = SH_W'(28);
    localparam logic [SH_W-1:0] SH_GAIN  = SH_W'(8);
    localparam logic [SH_W-1:0] SH_POWER = SH_W'(6);
    localparam logic [SH_W-1:0] SH_INV   = SH_W'(14);

    localparam logic [MUL_B_W-1:0] INV_SQRT3_Q14 = MUL_B_W'(9459);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = CFG_IDX_W'(1);
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(5760);
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = GAIN_W'(69120);

    typedef logic signed [TRIG_W-1:0] trig_t;

    function automatic trig_t hall_cos(input logic [HALL_W-1:0] code);
        case (code)
            3'b101:  return trig_t'(8192);
            3'b100:  return -trig_t'(8192);
            3'b110:  return -trig_t'(16384);
            3'b010:  return -trig_t'(8192);
            3'b011:  return trig_t'(8192);
            default: return trig_t'(16384);
        endcase
    endfunction

    function automatic trig_t hall_sin(input logic [HALL_W-1:0] code);
        case (code)
            3'b101:  return trig_t'(14189);
            3'b100:  return trig_t'(14189);
            3'b110:  return trig_t'(0);
            3'b010:  return -trig_t'(14189);
            3'b011:  return -trig_t'(14189);
            default: return trig_t'(0);
        endcase
    endfunction

    // Shift right with rounding to nearest, ties away from zero.
    function automatic logic signed [ACC_W-1:0] round_shift(
        input logic signed [ACC_W-1:0] x,
        input logic [SH_W-1:0] sh
    );
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] half;
        logic [ACC_W-1:0] r;
        mag  = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
        half = ACC_W'(1) << (sh - SH_W'(1));
        r    = (mag + half) >> sh;
        return x[ACC_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic sat_ovf(input logic signed [ACC_W-1:0] x);
        return !((&x[ACC_W-1:OUT_W-1]) || !(|x[ACC_W-1:OUT_W-1]));
    endfunction

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        if (sat_ovf(x))
            return x[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        return x[OUT_W-1:0];
    endfunction

endpackage

>>> hdl/foc_current_loop_hall_sector.sv
// Field-oriented current loop with a Hall-sensor sector angle. Each input beat carries two
// phase-current counts, a Hall code and a Q10.6 power scale; the block runs the Clarke and
// Park transforms, two PI regulators with saturating integrators, the power scaling of Vq
// and the inverse Park transform, and returns one beat of saturated alpha/beta voltages and
// a saturation flag. All products go through one shared 33x25 multiplier and a 60-bit
// accumulator under a small sequencer, a multiply step and an accumulate step per term plus
// the rounding and integrator-update steps; the input stalls from acceptance until the
// result is in the output register, and longer if the previous result is still waiting at
// the last step. The finished result waits in an output register, so a new item is taken
// while it is still pending. Gains are written through the configuration port; the user
// must write them only while idle, since the block itself does not enforce it.
module foc_current_loop_hall_sector (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [foccl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [foccl_pkg::GAIN_W-1:0]           cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [foccl_pkg::ADC_BITS-1:0]         phase_a_current,
    input  logic [foccl_pkg::ADC_BITS-1:0]         phase_b_current,
    input  logic [foccl_pkg::HALL_W-1:0]           hall_code,
    input  logic [foccl_pkg::POWER_W-1:0]          power_scale,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [foccl_pkg::OUT_W-1:0]     volt_alpha,
    output logic signed [foccl_pkg::OUT_W-1:0]     volt_beta,
    output logic                                   sat_flag
);

    localparam int ST_W = 6;
    localparam logic [ST_W-1:0] ST_IDLE  = ST_W'(0);
    localparam logic [ST_W-1:0] ST_IB_M  = ST_W'(1);
    localparam logic [ST_W-1:0] ST_IB_A  = ST_W'(2);
    localparam logic [ST_W-1:0] ST_D1_M  = ST_W'(3);
    localparam logic [ST_W-1:0] ST_D1_A  = ST_W'(4);
    localparam logic [ST_W-1:0] ST_D2_M  = ST_W'(5);
    localparam logic [ST_W-1:0] ST_D2_A  = ST_W'(6);
    localparam logic [ST_W-1:0] ST_D_R   = ST_W'(7);
    localparam logic [ST_W-1:0] ST_Q1_M  = ST_W'(8);
    localparam logic [ST_W-1:0] ST_Q1_A  = ST_W'(9);
    localparam logic [ST_W-1:0] ST_Q2_M  = ST_W'(10);
    localparam logic [ST_W-1:0] ST_Q2_A  = ST_W'(11);
    localparam logic [ST_W-1:0] ST_Q_R   = ST_W'(12);
    localparam logic [ST_W-1:0] ST_INT   = ST_W'(13);
    localparam logic [ST_W-1:0] ST_PD1_M = ST_W'(14);
    localparam logic [ST_W-1:0] ST_PD1_A = ST_W'(15);
    localparam logic [ST_W-1:0] ST_PD2_M = ST_W'(16);
    localparam logic [ST_W-1:0] ST_PD2_A = ST_W'(17);
    localparam logic [ST_W-1:0] ST_PD_R  = ST_W'(18);
    localparam logic [ST_W-1:0] ST_PQ1_M = ST_W'(19);
    localparam logic [ST_W-1:0] ST_PQ1_A = ST_W'(20);
    localparam logic [ST_W-1:0] ST_PQ2_M = ST_W'(21);
    localparam logic [ST_W-1:0] ST_PQ2_A = ST_W'(22);
    localparam logic [ST_W-1:0] ST_PQ_R  = ST_W'(23);
    localparam logic [ST_W-1:0] ST_VS_M  = ST_W'(24);
    localparam logic [ST_W-1:0] ST_VS_A  = ST_W'(25);
    localparam logic [ST_W-1:0] ST_VS_R  = ST_W'(26);
    localparam logic [ST_W-1:0] ST_AL1_M = ST_W'(27);
    localparam logic [ST_W-1:0] ST_AL1_A = ST_W'(28);
    localparam logic [ST_W-1:0] ST_AL2_M = ST_W'(29);
    localparam logic [ST_W-1:0] ST_AL2_A = ST_W'(30);
    localparam logic [ST_W-1:0] ST_AL3_M = ST_W'(31);
    localparam logic [ST_W-1:0] ST_AL3_A = ST_W'(32);
    localparam logic [ST_W-1:0] ST_AL_R  = ST_W'(33);
    localparam logic [ST_W-1:0] ST_BE1_M = ST_W'(34);
    localparam logic [ST_W-1:0] ST_BE1_A = ST_W'(35);
    localparam logic [ST_W-1:0] ST_BE2_M = ST_W'(36);
    localparam logic [ST_W-1:0] ST_BE2_A = ST_W'(37);
    localparam logic [ST_W-1:0] ST_BE3_M = ST_W'(38);
    localparam logic [ST_W-1:0] ST_BE3_A = ST_W'(39);
    localparam logic [ST_W-1:0] ST_BE_R  = ST_W'(40);

    logic [ST_W-1:0] state_reg, state_next;

    logic [foccl_pkg::GAIN_W-1:0] kp_reg, kp_next;
    logic [foccl_pkg::GAIN_W-1:0] ki_reg, ki_next;

    logic [foccl_pkg::ADC_BITS-1:0] a_reg, a_next;
    logic [foccl_pkg::ADC_BITS-1:0] b_reg, b_next;
    foccl_pkg::trig_t                cos_reg, cos_next;
    foccl_pkg::trig_t                sin_reg, sin_next;
    logic [foccl_pkg::POWER_W-1:0]  pwr_reg, pwr_next;

    logic [foccl_pkg::IB_W-1:0]              ib_reg, ib_next;
    logic signed [foccl_pkg::ERR_W-1:0]      err_d_reg, err_d_next;
    logic signed [foccl_pkg::ERR_W-1:0]      err_q_reg, err_q_next;
    logic signed [foccl_pkg::OUT_W-1:0]      integ_d_reg, integ_d_next;
    logic signed [foccl_pkg::OUT_W-1:0]      integ_q_reg, integ_q_next;
    logic signed [foccl_pkg::OUT_W-1:0]      vd_reg, vd_next;
    logic signed [foccl_pkg::OUT_W-1:0]      vq_reg, vq_next;
    logic signed [foccl_pkg::VQS_W-1:0]      vqs_reg, vqs_next;
    logic signed [foccl_pkg::OUT_W-1:0]      valpha_reg, valpha_next;
    logic                                    flag_reg, flag_next;

    logic signed [foccl_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic signed [foccl_pkg::ACC_W-1:0]      acc_reg, acc_next;

    logic                                    out_valid_reg, out_valid_next;
    logic signed [foccl_pkg::OUT_W-1:0]      out_alpha_reg, out_alpha_next;
    logic signed [foccl_pkg::OUT_W-1:0]      out_beta_reg, out_beta_next;
    logic                                    out_flag_reg, out_flag_next;

    logic signed [foccl_pkg::MUL_A_W-1:0]    mul_a;
    logic signed [foccl_pkg::MUL_B_W-1:0]    mul_b;
    logic [foccl_pkg::SH_W-1:0]              rnd_sh;
    logic signed [foccl_pkg::ACC_W-1:0]      rnd_out;
    logic signed [foccl_pkg::ACC_W-1:0]      prod_ext;
    logic signed [foccl_pkg::ACC_W-1:0]      prod_hi;
    logic signed [foccl_pkg::ACC_W-1:0]      sum_d;
    logic signed [foccl_pkg::ACC_W-1:0]      sum_q;
    logic signed [foccl_pkg::MUL_A_W-1:0]    ia_op;
    logic signed [foccl_pkg::MUL_A_W-1:0]    ib_op;
    logic signed [foccl_pkg::MUL_A_W-1:0]    lo_op;
    logic signed [foccl_pkg::MUL_A_W-1:0]    hi_op;
    logic signed [foccl_pkg::MUL_B_W-1:0]    cos_op;
    logic signed [foccl_pkg::MUL_B_W-1:0]    sin_op;
    logic                                    in_accept;
    logic                                    out_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign volt_alpha = out_alpha_reg;
    assign volt_beta  = out_beta_reg;
    assign sat_flag   = out_flag_reg;

    assign ia_op  = foccl_pkg::MUL_A_W'({a_reg, 14'd0});
    assign ib_op  = foccl_pkg::MUL_A_W'(ib_reg);
    assign lo_op  = foccl_pkg::MUL_A_W'(vqs_reg[foccl_pkg::LO_W-1:0]);
    assign hi_op  = foccl_pkg::MUL_A_W'($signed(vqs_reg[foccl_pkg::VQS_W-1:foccl_pkg::LO_W]));
    assign cos_op = foccl_pkg::MUL_B_W'(cos_reg);
    assign sin_op = foccl_pkg::MUL_B_W'(sin_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IB_M:
            begin
                mul_a = foccl_pkg::MUL_A_W'({2'b00, a_reg} + {1'b0, b_reg, 1'b0});
                mul_b = foccl_pkg::INV_SQRT3_Q14;
            end
            ST_D1_M:  begin mul_a = ia_op; mul_b = cos_op; end
            ST_D2_M:  begin mul_a = ib_op; mul_b = sin_op; end
            ST_Q1_M:  begin mul_a = ia_op; mul_b = sin_op; end
            ST_Q2_M:  begin mul_a = ib_op; mul_b = cos_op; end
            ST_PD1_M:
            begin
                mul_a = foccl_pkg::MUL_A_W'(err_d_reg);
                mul_b = foccl_pkg::MUL_B_W'(kp_reg);
            end
            ST_PD2_M:
            begin
                mul_a = foccl_pkg::MUL_A_W'(integ_d_reg);
                mul_b = foccl_pkg::MUL_B_W'(ki_reg);
            end
            ST_PQ1_M:
            begin
                mul_a = foccl_pkg::MUL_A_W'(err_q_reg);
                mul_b = foccl_pkg::MUL_B_W'(kp_reg);
            end
            ST_PQ2_M:
            begin
                mul_a = foccl_pkg::MUL_A_W'(integ_q_reg);
                mul_b = foccl_pkg::MUL_B_W'(ki_reg);
            end
            ST_VS_M:
            begin
                mul_a = foccl_pkg::MUL_A_W'(vq_reg);
                mul_b = foccl_pkg::MUL_B_W'(pwr_reg);
            end
            ST_AL1_M: begin mul_a = foccl_pkg::MUL_A_W'(vd_reg); mul_b = cos_op; end
            ST_AL2_M: begin mul_a = lo_op; mul_b = sin_op; end
            ST_AL3_M: begin mul_a = hi_op; mul_b = sin_op; end
            ST_BE1_M: begin mul_a = foccl_pkg::MUL_A_W'(vd_reg); mul_b = sin_op; end
            ST_BE2_M: begin mul_a = lo_op; mul_b = cos_op; end
            ST_BE3_M: begin mul_a = hi_op; mul_b = cos_op; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_D_R, ST_Q_R:   rnd_sh = foccl_pkg::SH_PARK;
            ST_PD_R, ST_PQ_R: rnd_sh = foccl_pkg::SH_GAIN;
            ST_VS_R:          rnd_sh = foccl_pkg::SH_POWER;
            default:          rnd_sh = foccl_pkg::SH_INV;
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = foccl_pkg::ACC_W'(prod_reg);
    // The high piece of the scaled Vq carries a weight of two to the LO_W.
    assign prod_hi   = prod_ext <<< foccl_pkg::LO_W;
    assign rnd_out   = foccl_pkg::round_shift(acc_reg, rnd_sh);
    assign sum_d     = foccl_pkg::ACC_W'(integ_d_reg) + foccl_pkg::ACC_W'(err_d_reg);
    assign sum_q     = foccl_pkg::ACC_W'(integ_q_reg) + foccl_pkg::ACC_W'(err_q_reg);

    always_comb
    begin
        state_next     = state_reg;
        kp_next        = kp_reg;
        ki_next        = ki_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cos_next       = cos_reg;
        sin_next       = sin_reg;
        pwr_next       = pwr_reg;
        ib_next        = ib_reg;
        err_d_next     = err_d_reg;
        err_q_next     = err_q_reg;
        integ_d_next   = integ_d_reg;
        integ_q_next   = integ_q_reg;
        vd_next        = vd_reg;
        vq_next        = vq_reg;
        vqs_next       = vqs_reg;
        valpha_next    = valpha_reg;
        flag_next      = flag_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_alpha_next = out_alpha_reg;
        out_beta_next  = out_beta_reg;
        out_flag_next  = out_flag_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == foccl_pkg::REG_PROP_GAIN)
                kp_next = cfg_data;
            else if (cfg_index == foccl_pkg::REG_INTEG_GAIN)
                ki_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    a_next     = phase_a_current;
                    b_next     = phase_b_current;
                    cos_next   = foccl_pkg::hall_cos(hall_code);
                    sin_next   = foccl_pkg::hall_sin(hall_code);
                    pwr_next   = power_scale;
                    flag_next  = 1'b0;
                    state_next = ST_IB_M;
                end
            end
            ST_IB_A:
            begin
                ib_next    = prod_reg[foccl_pkg::IB_W-1:0];
                state_next = ST_D1_M;
            end
            ST_D1_A, ST_PD1_A, ST_PQ1_A, ST_VS_A, ST_AL1_A, ST_BE1_A:
            begin
                acc_next   = prod_ext;
                state_next = state_reg + ST_W'(1);
            end
            ST_Q1_A:
            begin
                acc_next   = -prod_ext;
                state_next = ST_Q2_M;
            end
            ST_D2_A, ST_Q2_A, ST_PD2_A, ST_PQ2_A, ST_BE2_A:
            begin
                acc_next   = acc_reg + prod_ext;
                state_next = state_reg + ST_W'(1);
            end
            ST_AL2_A:
            begin
                acc_next   = acc_reg - prod_ext;
                state_next = ST_AL3_M;
            end
            ST_AL3_A:
            begin
                acc_next   = acc_reg - prod_hi;
                state_next = ST_AL_R;
            end
            ST_BE3_A:
            begin
                acc_next   = acc_reg + prod_hi;
                state_next = ST_BE_R;
            end
            ST_D_R:
            begin
                err_d_next = foccl_pkg::ERR_W'(-rnd_out);
                state_next = ST_Q1_M;
            end
            ST_Q_R:
            begin
                err_q_next = foccl_pkg::ERR_W'(-rnd_out);
                state_next = ST_INT;
            end
            ST_INT:
            begin
                integ_d_next = foccl_pkg::sat32(sum_d);
                integ_q_next = foccl_pkg::sat32(sum_q);
                flag_next    = flag_reg || foccl_pkg::sat_ovf(sum_d)
                               || foccl_pkg::sat_ovf(sum_q);
                state_next   = ST_PD1_M;
            end
            ST_PD_R:
            begin
                vd_next    = foccl_pkg::sat32(rnd_out);
                flag_next  = flag_reg || foccl_pkg::sat_ovf(rnd_out);
                state_next = ST_PQ1_M;
            end
            ST_PQ_R:
            begin
                vq_next    = foccl_pkg::sat32(rnd_out);
                flag_next  = flag_reg || foccl_pkg::sat_ovf(rnd_out);
                state_next = ST_VS_M;
            end
            ST_VS_R:
            begin
                vqs_next   = rnd_out[foccl_pkg::VQS_W-1:0];
                state_next = ST_AL1_M;
            end
            ST_AL_R:
            begin
                valpha_next = foccl_pkg::sat32(rnd_out);
                flag_next   = flag_reg || foccl_pkg::sat_ovf(rnd_out);
                state_next  = ST_BE1_M;
            end
            ST_BE_R:
            begin
                // Hold here until the output register is free for the new beat.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_alpha_next = valpha_reg;
                    out_beta_next  = foccl_pkg::sat32(rnd_out);
                    out_flag_next  = flag_reg || foccl_pkg::sat_ovf(rnd_out);
                    state_next     = ST_IDLE;
                end
            end
            ST_IB_M, ST_D1_M, ST_D2_M, ST_Q1_M, ST_Q2_M, ST_PD1_M, ST_PD2_M,
            ST_PQ1_M, ST_PQ2_M, ST_VS_M, ST_AL1_M, ST_AL2_M, ST_AL3_M,
            ST_BE1_M, ST_BE2_M, ST_BE3_M:
            begin
                state_next = state_reg + ST_W'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kp_reg        <= foccl_pkg::PROP_GAIN_RST;
            ki_reg        <= foccl_pkg::INTEG_GAIN_RST;
            integ_d_reg   <= '0;
            integ_q_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            integ_d_reg   <= integ_d_next;
            integ_q_reg   <= integ_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        cos_reg       <= cos_next;
        sin_reg       <= sin_next;
        pwr_reg       <= pwr_next;
        ib_reg        <= ib_next;
        err_d_reg     <= err_d_next;
        err_q_reg     <= err_q_next;
        vd_reg        <= vd_next;
        vq_reg        <= vq_next;
        vqs_reg       <= vqs_next;
        valpha_reg    <= valpha_next;
        flag_reg      <= flag_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        out_alpha_reg <= out_alpha_next;
        out_beta_reg  <= out_beta_next;
        out_flag_reg  <= out_flag_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("block took a beat but did not go busy");

    a_out_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_BE_R))
        else $error("result appeared outside the final step");

    a_integ_d_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_INT) |=> $stable(integ_d_reg))
        else $error("direct integrator changed outside its update step");

    a_integ_q_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_INT) |=> $stable(integ_q_reg))
        else $error("quadrature integrator changed outside its update step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("pending result dropped while stalled");

endmodule
